[hdl/token_bucket_rate_limiter_core_macros.svh]
// assertion macros used by the token bucket limiter checker
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define TBRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define TBRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tbrl_pkg.sv]
// shared types and constants for the token bucket limiter
`timescale 1ns / 1ps

package tbrl_pkg;

  localparam int TIME_W  = 64;
  localparam int LEVEL_W = 26;
  localparam int RATE_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W  = LEVEL_W + RATE_W;
  localparam int OUT_TDATA_W = 8;

  localparam logic [LEVEL_W-1:0] MILLI_PER_TOKEN = 26'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BURST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE  = 1'd1;

  // reset values of the registers
  localparam logic [CFG_W-1:0]   BURST_RST = 16'd8;
  localparam logic [RATE_W-1:0]  RATE_RST  = 16'd100;
  localparam logic [LEVEL_W-1:0] CAP_RST   = 26'd8000;

  // time stage to gain stage
  typedef struct packed {
    logic               prime;
    logic               adv;
    logic               big;
    logic [LEVEL_W-1:0] elapsed;
  } tbrl_time_t;

  // gain stage to level stage
  typedef struct packed {
    logic               prime;
    logic [LEVEL_W-1:0] gain;
  } tbrl_gain_t;

endpackage

[hdl/tbrl_time_stage.sv]
// input register and elapsed-time stage, owns last refill time and primed flag
`timescale 1ns / 1ps

module tbrl_time_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tbrl_pkg::TIME_W-1:0]  in_now,
  input  logic [tbrl_pkg::LEVEL_W-1:0] cap,
  input  logic                        prime_clr,
  output logic                        s_valid,
  input  logic                        s_ready,
  output tbrl_pkg::tbrl_time_t         s_data
);
  import tbrl_pkg::*;

  logic               a_valid_r;
  logic [TIME_W-1:0]  a_now_r;
  logic               b_valid_r;
  tbrl_time_t         b_data_r;
  tbrl_time_t         b_data_nxt;
  logic [TIME_W-1:0]  last_r;
  logic [TIME_W-1:0]  last_nxt;
  logic               primed_r;
  logic               b_ready;
  logic               a_fire;
  logic               later;
  logic [TIME_W-1:0]  elapsed;

  // stage handshake
  assign b_ready  = !b_valid_r || s_ready;
  assign a_fire   = a_valid_r && b_ready;
  assign in_ready = !a_valid_r || b_ready;
  assign s_valid  = b_valid_r;
  assign s_data   = b_data_r;

  // elapsed time against last refill
  always_comb begin
    later   = a_now_r > last_r;
    elapsed = a_now_r - last_r;
    b_data_nxt.prime   = !primed_r;
    b_data_nxt.adv     = primed_r && later;
    b_data_nxt.big     = elapsed > {{(TIME_W-LEVEL_W){1'b0}}, cap};
    b_data_nxt.elapsed = elapsed[LEVEL_W-1:0];
    last_nxt = (!primed_r || later) ? a_now_r : last_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      primed_r  <= 1'b0;
      last_r    <= '0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (a_fire) begin
        last_r <= last_nxt;
      end
      // a register write re-arms priming, otherwise a taken item primes
      if (prime_clr) begin
        primed_r <= 1'b0;
      end else if (a_fire) begin
        primed_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_now_r <= in_now;
    end
    if (a_fire) begin
      b_data_r <= b_data_nxt;
    end
  end

endmodule

[hdl/tbrl_gain_stage.sv]
// refill gain stage: elapsed times rate, held at the cap
`timescale 1ns / 1ps

module tbrl_gain_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        i_valid,
  output logic                        i_ready,
  input  tbrl_pkg::tbrl_time_t         i_data,
  input  logic [tbrl_pkg::LEVEL_W-1:0] cap,
  input  logic [tbrl_pkg::RATE_W-1:0]  rate,
  output logic                        o_valid,
  input  logic                        o_ready,
  output tbrl_pkg::tbrl_gain_t         o_data
);
  import tbrl_pkg::*;

  logic               valid_r;
  tbrl_gain_t         data_r;
  tbrl_gain_t         data_nxt;
  logic [PROD_W-1:0]  prod;

  assign i_ready = !valid_r || o_ready;
  assign o_valid = valid_r;
  assign o_data  = data_r;

  // gain select: none, full cap for a long idle span, else clamped product
  always_comb begin
    prod = {{RATE_W{1'b0}}, i_data.elapsed} * {{LEVEL_W{1'b0}}, rate};
    data_nxt.prime = i_data.prime;
    if (!i_data.adv) begin
      data_nxt.gain = '0;
    end else if (i_data.big) begin
      data_nxt.gain = cap;
    end else if (prod > {{RATE_W{1'b0}}, cap}) begin
      data_nxt.gain = cap;
    end else begin
      data_nxt.gain = prod[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hdl/tbrl_level_stage.sv]
// token level update and result register
`timescale 1ns / 1ps

module tbrl_level_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        i_valid,
  output logic                        i_ready,
  input  tbrl_pkg::tbrl_gain_t         i_data,
  input  logic [tbrl_pkg::LEVEL_W-1:0] cap,
  output logic                        o_valid,
  input  logic                        o_ready,
  output logic                        o_granted
);
  import tbrl_pkg::*;

  logic               valid_r;
  logic               granted_r;
  logic               granted_nxt;
  logic [LEVEL_W-1:0] level_r;
  logic [LEVEL_W-1:0] level_nxt;
  logic [LEVEL_W-1:0] base;
  logic [LEVEL_W:0]   total;
  logic [LEVEL_W-1:0] sat;
  logic               fire;

  assign i_ready   = !valid_r || o_ready;
  assign fire      = i_valid && i_ready;
  assign o_valid   = valid_r;
  assign o_granted = granted_r;

  // refill, saturate at the cap, then spend one token if there is one
  always_comb begin
    base  = i_data.prime ? cap : level_r;
    total = {1'b0, base} + {1'b0, i_data.gain};
    sat   = (total > {1'b0, cap}) ? cap : total[LEVEL_W-1:0];
    granted_nxt = sat >= MILLI_PER_TOKEN;
    level_nxt   = granted_nxt ? (sat - MILLI_PER_TOKEN) : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      level_r <= '0;
    end else begin
      if (i_ready) begin
        valid_r <= i_valid;
      end
      if (fire) begin
        level_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      granted_r <= granted_nxt;
    end
  end

endmodule

[hdl/token_bucket_rate_limiter_core.sv]
// top level of the token bucket admission limiter
// Token bucket admission limiter. Each item on the in_ stream is one request
// carrying the current time in milliseconds; each item on the out_ stream is
// the matching answer, bit 0 set when a token was spent and the request
// admitted. Results come back in request order, one per request; with no
// stall a new request is taken every cycle. Each answer passes through the
// four-stage pipeline (input register, elapsed time, refill gain multiply,
// level update and result register), each stage holding only when the
// stage after it is full and stalled. The first request after reset or after
// any register write fills the bucket to burst_tokens * 1000 milli-tokens.
// Registers are to be written through cfg_ only while no request is in
// flight; the block does not enforce this. Index 0 is burst_tokens,
// index 1 refill_rate_per_s.
`timescale 1ns / 1ps

module token_bucket_rate_limiter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [63:0] now_ms
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tbrl_pkg::TIME_W-1:0]    in_tdata,
  // out_tdata: [0] granted, [7:1] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tbrl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbrl_pkg::CFG_W-1:0]     cfg_wdata
);
  import tbrl_pkg::*;

  logic [LEVEL_W-1:0] cap_r;
  logic [RATE_W-1:0]  rate_r;
  logic               prime_clr;
  logic               t_valid;
  logic               t_ready;
  tbrl_time_t         t_data;
  logic               g_valid;
  logic               g_ready;
  tbrl_gain_t         g_data;
  logic               granted;

  // any write to a known register re-primes the bucket
  assign prime_clr = cfg_we && ((cfg_index == CFG_IDX_BURST) || (cfg_index == CFG_IDX_RATE));

  // configuration registers, cap kept in milli-tokens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RST;
      rate_r <= RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_BURST: cap_r  <= LEVEL_W'(cfg_wdata) * MILLI_PER_TOKEN;
        CFG_IDX_RATE:  rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbrl_time_stage u_time (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_now    (in_tdata),
    .cap       (cap_r),
    .prime_clr (prime_clr),
    .s_valid   (t_valid),
    .s_ready   (t_ready),
    .s_data    (t_data)
  );

  tbrl_gain_stage u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (t_valid),
    .i_ready (t_ready),
    .i_data  (t_data),
    .cap     (cap_r),
    .rate    (rate_r),
    .o_valid (g_valid),
    .o_ready (g_ready),
    .o_data  (g_data)
  );

  tbrl_level_stage u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (g_valid),
    .i_ready   (g_ready),
    .i_data    (g_data),
    .cap       (cap_r),
    .o_valid   (out_tvalid),
    .o_ready   (out_tready),
    .o_granted (granted)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, granted};

endmodule

[hdl/tbrl_checker.sv]
// port-level checker for the token bucket limiter, bound to the top level
`timescale 1ns / 1ps
`include "token_bucket_rate_limiter_core_macros.svh"

module tbrl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [tbrl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tbrl_pkg::*;

  // a held result keeps its value
  `TBRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // pad bits of the result stay zero
  `TBRL_ASSERT_NOW(a_out_pad, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:1] == '0, "result pad bits set")

  // with the result register empty every stage can move, so input is open
  `TBRL_ASSERT_NOW(a_in_open, clk, rst_n, !out_tvalid, in_tready, "input blocked while output empty")

  // reset empties the pipeline
  `TBRL_ASSERT_NOW(a_rst_empty, clk, rst_n, $past(!rst_n), !out_tvalid, "result present right after reset")

endmodule

bind token_bucket_rate_limiter_core tbrl_checker u_tbrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/token_bucket_rate_limiter_core_tb.sv]
// self-checking testbench for the token bucket admission limiter core
`timescale 1ns / 1ps

module token_bucket_rate_limiter_core_tb;
  import tbrl_pkg::*;

  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 244;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 12;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_mode_e;

  // one directed step: a register write or a request with an optional typed answer
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     wdata;
    logic [TIME_W-1:0]    now;
    logic                 typed;
    logic                 grant;
  } dir_row_t;

  localparam int DIR_ROWS = 29;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TIME_W-1:0]      in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_IDX_BURST;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // shadow of the block: registers and bucket state
  logic [CFG_W-1:0]   reg_burst = BURST_RST;
  logic [RATE_W-1:0]  reg_rate = RATE_RST;
  logic [LEVEL_W-1:0] bkt_level = '0;
  logic [TIME_W-1:0]  bkt_last = '0;
  logic               bkt_primed = 1'b0;

  // answers still owed by the block, oldest first
  logic grant_q[$];

  flow_mode_e flow = FLOW_FREE;
  int errors = 0;
  int cycles = 0;
  int n_req = 0;
  int n_grant = 0;
  int n_deny = 0;
  int n_cfg = 0;
  logic [OUT_TDATA_W-1:0] want;
  logic                   want_grant;

  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    // fresh bucket after reset: eight tokens, then empty
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1000, 1'b1, 1'b0},
    // partial refills
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1005, 1'b0, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd1010, 1'b0, 1'b0},
    // time going backwards, then a very long idle span
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd0,    1'b1, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, T_MAX,    1'b1, 1'b1},
    // zero capacity denies everything
    '{1'b1, CFG_IDX_BURST, 16'd0, 64'd0,    1'b0, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd12345, 1'b1, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, T_MAX,    1'b1, 1'b0},
    // largest capacity and rate
    '{1'b1, CFG_IDX_BURST, 16'hFFFF, 64'd0, 1'b0, 1'b0},
    '{1'b1, CFG_IDX_RATE,  16'hFFFF, 64'd0, 1'b0, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd5,    1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd6,    1'b0, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
    // zero rate never refills after priming
    '{1'b1, CFG_IDX_RATE,  16'd0, 64'd0,    1'b0, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd0,    1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'd100000000, 1'b0, 1'b0},
    // single token bucket at the top of the time range
    '{1'b1, CFG_IDX_BURST, 16'd1, 64'd0,    1'b0, 1'b0},
    '{1'b1, CFG_IDX_RATE,  16'd1, 64'd0,    1'b0, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, T_MAX,    1'b1, 1'b1},
    '{1'b0, CFG_IDX_BURST, 16'd0, T_MAX,    1'b1, 1'b0},
    '{1'b0, CFG_IDX_BURST, 16'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0}
  };

  token_bucket_rate_limiter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // refill, clamp and spend one token for a request stamped t
  function automatic logic bucket_admit(input logic [TIME_W-1:0] t);
    logic [63:0] cap;
    logic [63:0] lvl;
    logic [63:0] gap;
    logic [63:0] gain;
    logic [63:0] cost;
    cap  = 64'(reg_burst) * 64'(MILLI_PER_TOKEN);
    cost = 64'(MILLI_PER_TOKEN);
    if (!bkt_primed) begin
      bkt_level  = cap[LEVEL_W-1:0];
      bkt_last   = t;
      bkt_primed = 1'b1;
    end
    lvl = 64'(bkt_level);
    if (t > bkt_last) begin
      gap  = t - bkt_last;
      gain = (gap > cap) ? cap : gap * 64'(reg_rate);
      if (gain > cap) begin
        gain = cap;
      end
      lvl = (lvl + gain > cap) ? cap : lvl + gain;
      bkt_last = t;
    end
    if (lvl < cost) begin
      bkt_level = lvl[LEVEL_W-1:0];
      return 1'b0;
    end
    lvl = lvl - cost;
    bkt_level = lvl[LEVEL_W-1:0];
    return 1'b1;
  endfunction

  function automatic int send_gap_pct();
    case (flow)
      FLOW_SRC_GAPS: return 78;
      FLOW_BOTH:     return 12;
      default:       return 0;
    endcase
  endfunction

  // offer one request, hold it until taken, then log the expected answer
  task automatic send_req(input logic [TIME_W-1:0] t, input logic typed,
                          input logic typed_grant);
    logic g;
    while ($urandom_range(99) < send_gap_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = bucket_admit(t);
    grant_q.push_back(typed ? typed_grant : g);
    n_req++;
  endtask

  // register write once the pipeline has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_BURST) begin
      reg_burst = val;
    end else begin
      reg_rate = val;
    end
    bkt_primed = 1'b0;
    n_cfg++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    case (flow)
      FLOW_SINK_STALLS: out_tready <= ($urandom_range(99) >= 78);
      FLOW_BOTH:        out_tready <= ($urandom_range(99) >= 12);
      default:          out_tready <= 1'b1;
    endcase
  end

  // compare each answer with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual tdata %h", $time, out_tdata);
      end else begin
        want_grant = grant_q.pop_front();
        want       = '0;
        want[0]    = want_grant;
        if (out_tdata !== want) begin
          errors++;
          $display("%0t: granted mismatch, expected %h actual %h", $time, want, out_tdata);
        end
        if (out_tdata[0]) n_grant++;
        else n_deny++;
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, grant_q.size());
      $display("token_bucket_rate_limiter_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] t;
    int pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed steps
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].wdata);
      end else begin
        send_req(dir_tab[i].now, dir_tab[i].typed, dir_tab[i].grant);
      end
    end

    // random phases, each with its own flow control and bucket settings
    wall = 64'({$urandom} % 100000);
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      flow = flow_mode_e'(ph % 4);
      case (ph)
        0: begin
          write_reg(CFG_IDX_BURST, 16'd1);
          write_reg(CFG_IDX_RATE, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_IDX_BURST, 16'hFFFF);
          write_reg(CFG_IDX_RATE, 16'd1);
        end
        default: begin
          write_reg(CFG_IDX_BURST, CFG_W'($urandom_range(1, 12)));
          write_reg(CFG_IDX_RATE, RATE_W'($urandom_range(0, 1500)));
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // steady clock with small steps
          wall = wall + 64'($urandom_range(0, 15));
          t = wall;
        end else if (pick < 88) begin
          // stale timestamp
          t = wall - 64'($urandom_range(1, 50));
        end else if (pick < 94) begin
          // long idle span
          wall = wall + ({$urandom, $urandom} >> $urandom_range(20, 63));
          t = wall;
        end else begin
          // arbitrary timestamp, clock follows it
          t = {$urandom, $urandom};
          wall = t;
        end
        send_req(t, 1'b0, 1'b0);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    flow = FLOW_FREE;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d requests (%0d granted, %0d denied) over %0d register writes",
             n_req, n_grant, n_deny, n_cfg);
    $display("flow modes: free, sender gaps, receiver stalls, both; %0d errors", errors);
    if (errors == 0) begin
      $display("token_bucket_rate_limiter_core_tb: PASS");
    end else begin
      $display("token_bucket_rate_limiter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
